[hdl/fpqr_pkg.sv]
// Shared types, constants and helpers for the false position quartic root finder.
package fpqr_pkg;

    localparam int X_W       = 20;               // signed Q3.16 operand width
    localparam int FRAC_BITS = 16;
    localparam int TOL_W     = 16;
    localparam int BW_W      = 19;
    localparam int CFG_W     = 19;               // widest config register
    localparam int F_W       = 32;               // quartic value, signed
    localparam int SQP_W     = 2 * X_W;          // x*x product
    localparam int SQ_W      = SQP_W - FRAC_BITS;
    localparam int QUP_W     = 2 * SQ_W;         // sq*sq product
    localparam int P_W       = X_W + F_W;        // x*f product
    localparam int NUM_W     = P_W + 1;          // cross-product difference
    localparam int DEN_W     = F_W + 1;          // f2 - f1
    localparam int CNT_OUT_W = 7;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_ITERATIONS_DEF = 64;

    localparam logic signed [X_W-1:0] X_MAX_V = {1'b0, {(X_W-1){1'b1}}};
    localparam logic signed [X_W-1:0] X_MIN_V = {1'b1, {(X_W-1){1'b0}}};
    localparam logic [TOL_W-1:0]      TOL_RST = 16'd66;
    localparam logic [BW_W-1:0]       BW_RST  = 19'd32768;
    localparam logic [F_W+1:0]        F_FOUR  = (F_W+2)'(4) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BRACKET_WIDTH = 1'b1;

    typedef logic signed [X_W-1:0] fix_t;
    typedef logic signed [F_W-1:0] fval_t;

    typedef struct packed {
        fix_t lo;
        fix_t hi;
    } job_t;

    typedef enum logic [STAT_W-1:0] {
        ST_NONE = 3'd0,
        ST_LOW  = 3'd1,
        ST_HIGH = 3'd2,
        ST_ITER = 3'd3,
        ST_CAP  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_QU, S_FV, S_DISP, S_CHECK,
        S_MUL1, S_MUL2, S_DIVGO, S_DIVWAIT, S_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        PH_F1, PH_F2, PH_F0
    } phase_t;

    // |v| < tol
    function automatic logic below_tol(input fval_t v, input logic [TOL_W-1:0] tol);
        logic [F_W-1:0] m;
        m = v[F_W-1] ? F_W'(-v) : F_W'(v);
        return m < F_W'(tol);
    endfunction

    function automatic logic sign_change(input fval_t a, input fval_t b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

endpackage

[hdl/fpqr_front.sv]
// Front end: builds the bracket for one request, high end saturated.
module fpqr_front (
    input  fpqr_pkg::fix_t                 bracket_low,
    input  logic [fpqr_pkg::BW_W-1:0]      bracket_width,
    output fpqr_pkg::job_t                 job
);

    localparam int SUM_W = fpqr_pkg::X_W + 2;

    logic signed [SUM_W-1:0] hi_sum;

    always_comb
    begin
        hi_sum = SUM_W'(bracket_low) + $signed({3'b000, bracket_width});
        job.lo = bracket_low;
        if (hi_sum > SUM_W'(fpqr_pkg::X_MAX_V))
        begin
            job.hi = fpqr_pkg::X_MAX_V;
        end
        else
        begin
            job.hi = hi_sum[fpqr_pkg::X_W-1:0];
        end
    end

endmodule

[hdl/fpqr_queue.sv]
// Two-entry job queue between front and back end.
module fpqr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fpqr_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output fpqr_pkg::job_t pop_job,
    output logic           empty
);

    fpqr_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hdl/fpqr_div.sv]
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module fpqr_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [fpqr_pkg::NUM_W-1:0]   num,
    input  logic signed [fpqr_pkg::DEN_W-1:0]   den,
    output logic                                done,
    output logic signed [fpqr_pkg::NUM_W-1:0]   quo
);

    localparam int NW = fpqr_pkg::NUM_W;
    localparam int DW = fpqr_pkg::DEN_W;
    localparam int CW = $clog2(NW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dmag_reg, dmag_next;
    logic          neg_reg, neg_next;
    logic [DW:0]   trial;

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, quo_reg[NW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW - 1);
            rem_next  = '0;
            quo_next  = num[NW-1] ? NW'(-num) : NW'(num);
            dmag_next = den[DW-1] ? DW'(-den) : DW'(den);
            neg_next  = num[NW-1] ^ den[DW-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dmag_reg})
            begin
                rem_next = DW'(trial - {1'b0, dmag_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

endmodule

[hdl/fpqr_back.sv]
// Back end: quartic evaluation, false position sequencer and result register.
module fpqr_back #(
    parameter int MAX_ITERATIONS = fpqr_pkg::MAX_ITERATIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_valid,
    input  fpqr_pkg::job_t                    job,
    output logic                              job_pop,
    input  logic [fpqr_pkg::TOL_W-1:0]        tolerance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output fpqr_pkg::fix_t                    root_value,
    output logic [fpqr_pkg::STAT_W-1:0]       status,
    output logic [fpqr_pkg::CNT_OUT_W-1:0]    iteration_count
);

    localparam int CW = $clog2(MAX_ITERATIONS + 1);
    localparam int XW = fpqr_pkg::X_W;
    localparam int FW = fpqr_pkg::F_W;

    fpqr_pkg::back_state_t state_reg, state_next;
    fpqr_pkg::phase_t      phase_reg, phase_next;
    fpqr_pkg::status_t     stat_reg, stat_next;

    fpqr_pkg::fix_t x1_reg, x1_next, x2_reg, x2_next, x0_reg, x0_next;
    fpqr_pkg::fix_t ex_reg, ex_next, root_reg, root_next;
    fpqr_pkg::fval_t f1_reg, f1_next, f2_reg, f2_next, f0_reg, f0_next;
    logic signed [fpqr_pkg::SQP_W-1:0] sqp_reg, sqp_next;
    logic [fpqr_pkg::SQ_W-1:0]         sq_reg, sq_next;
    logic [fpqr_pkg::QUP_W-1:0]        qup_reg, qup_next;
    logic signed [fpqr_pkg::P_W-1:0]   p1_reg, p1_next, p2_reg, p2_next;
    logic [CW-1:0]                     cnt_reg, cnt_next;

    fpqr_pkg::fix_t                      out_root_reg, out_root_next;
    logic [fpqr_pkg::STAT_W-1:0]         out_stat_reg, out_stat_next;
    logic [fpqr_pkg::CNT_OUT_W-1:0]      out_cnt_reg, out_cnt_next;
    logic                                out_valid_reg, out_valid_next;

    logic [fpqr_pkg::SQ_W-1:0]           sq_cur;
    logic signed [FW+1:0]                fv;
    logic signed [XW:0]                  dx;
    logic [XW:0]                         dx_mag;
    logic                                div_start, div_done;
    logic signed [fpqr_pkg::NUM_W-1:0]   div_num, div_quo;
    logic signed [fpqr_pkg::DEN_W-1:0]   div_den;
    fpqr_pkg::fix_t                      q_clamp;

    fpqr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_valid       = out_valid_reg;
    assign root_value      = out_root_reg;
    assign status          = out_stat_reg;
    assign iteration_count = out_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        stat_next      = stat_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        x0_next        = x0_reg;
        ex_next        = ex_reg;
        root_next      = root_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        f0_next        = f0_reg;
        sqp_next       = sqp_reg;
        sq_next        = sq_reg;
        qup_next       = qup_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        cnt_next       = cnt_reg;
        out_root_next  = out_root_reg;
        out_stat_next  = out_stat_reg;
        out_cnt_next   = out_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        job_pop        = 1'b0;
        div_start      = 1'b0;

        sq_cur  = sqp_reg[fpqr_pkg::SQP_W-1:fpqr_pkg::FRAC_BITS];
        fv      = $signed({2'b00, qup_reg[fpqr_pkg::QUP_W-1:fpqr_pkg::FRAC_BITS]})
                  - $signed((FW+2)'(sq_reg) * (FW+2)'(5))
                  + $signed(fpqr_pkg::F_FOUR);
        dx      = (XW+1)'(x2_reg) - (XW+1)'(x1_reg);
        dx_mag  = dx[XW] ? (XW+1)'(-dx) : (XW+1)'(dx);
        div_num = fpqr_pkg::NUM_W'(p1_reg) - fpqr_pkg::NUM_W'(p2_reg);
        div_den = fpqr_pkg::DEN_W'(f2_reg) - fpqr_pkg::DEN_W'(f1_reg);

        if (div_quo > fpqr_pkg::NUM_W'(fpqr_pkg::X_MAX_V))
            q_clamp = fpqr_pkg::X_MAX_V;
        else if (div_quo < fpqr_pkg::NUM_W'(fpqr_pkg::X_MIN_V))
            q_clamp = fpqr_pkg::X_MIN_V;
        else
            q_clamp = div_quo[XW-1:0];

        unique case (state_reg)
            fpqr_pkg::S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    x1_next    = job.lo;
                    x2_next    = job.hi;
                    x0_next    = job.lo;
                    ex_next    = job.lo;
                    cnt_next   = '0;
                    phase_next = fpqr_pkg::PH_F1;
                    state_next = fpqr_pkg::S_SQ;
                end
            end
            fpqr_pkg::S_SQ:
            begin
                sqp_next   = ex_reg * ex_reg;
                state_next = fpqr_pkg::S_QU;
            end
            fpqr_pkg::S_QU:
            begin
                sq_next    = sq_cur;
                qup_next   = sq_cur * sq_cur;
                state_next = fpqr_pkg::S_FV;
            end
            fpqr_pkg::S_FV:
            begin
                f0_next    = fv[FW-1:0];
                state_next = fpqr_pkg::S_DISP;
            end
            fpqr_pkg::S_DISP:
            begin
                unique case (phase_reg)
                    fpqr_pkg::PH_F1:
                    begin
                        f1_next    = f0_reg;
                        ex_next    = x2_reg;
                        phase_next = fpqr_pkg::PH_F2;
                        state_next = fpqr_pkg::S_SQ;
                    end
                    fpqr_pkg::PH_F2:
                    begin
                        f2_next = f0_reg;
                        if (fpqr_pkg::below_tol(f1_reg, tolerance))
                        begin
                            root_next  = x1_reg;
                            stat_next  = fpqr_pkg::ST_LOW;
                            state_next = fpqr_pkg::S_DONE;
                        end
                        else if (fpqr_pkg::below_tol(f0_reg, tolerance))
                        begin
                            root_next  = x2_reg;
                            stat_next  = fpqr_pkg::ST_HIGH;
                            state_next = fpqr_pkg::S_DONE;
                        end
                        else if (fpqr_pkg::sign_change(f1_reg, f0_reg))
                        begin
                            stat_next  = fpqr_pkg::ST_ITER;
                            state_next = fpqr_pkg::S_CHECK;
                        end
                        else
                        begin
                            root_next  = '0;
                            stat_next  = fpqr_pkg::ST_NONE;
                            state_next = fpqr_pkg::S_DONE;
                        end
                    end
                    default:
                    begin
                        if (fpqr_pkg::below_tol(f0_reg, tolerance))
                        begin
                            root_next  = x0_reg;
                            state_next = fpqr_pkg::S_DONE;
                        end
                        else
                        begin
                            if (fpqr_pkg::sign_change(f0_reg, f1_reg))
                            begin
                                x2_next = x0_reg;
                                f2_next = f0_reg;
                            end
                            else
                            begin
                                x1_next = x0_reg;
                                f1_next = f0_reg;
                            end
                            state_next = fpqr_pkg::S_CHECK;
                        end
                    end
                endcase
            end
            fpqr_pkg::S_CHECK:
            begin
                root_next = x0_reg;
                if (dx_mag <= (XW+1)'(tolerance))
                begin
                    state_next = fpqr_pkg::S_DONE;
                end
                else if (32'(cnt_reg) >= 32'(MAX_ITERATIONS))
                begin
                    stat_next  = fpqr_pkg::ST_CAP;
                    state_next = fpqr_pkg::S_DONE;
                end
                else if (f2_reg == f1_reg)
                begin
                    state_next = fpqr_pkg::S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = fpqr_pkg::S_MUL1;
                end
            end
            fpqr_pkg::S_MUL1:
            begin
                p1_next    = x1_reg * f2_reg;
                state_next = fpqr_pkg::S_MUL2;
            end
            fpqr_pkg::S_MUL2:
            begin
                p2_next    = x2_reg * f1_reg;
                state_next = fpqr_pkg::S_DIVGO;
            end
            fpqr_pkg::S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = fpqr_pkg::S_DIVWAIT;
            end
            fpqr_pkg::S_DIVWAIT:
            begin
                if (div_done)
                begin
                    x0_next    = q_clamp;
                    ex_next    = q_clamp;
                    phase_next = fpqr_pkg::PH_F0;
                    state_next = fpqr_pkg::S_SQ;
                end
            end
            fpqr_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_root_next  = root_reg;
                    out_stat_next  = stat_reg;
                    out_cnt_next   = (32'(cnt_reg) > 32'd127) ? 7'd127
                                                              : fpqr_pkg::CNT_OUT_W'(cnt_reg);
                    out_valid_next = 1'b1;
                    state_next     = fpqr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fpqr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpqr_pkg::S_IDLE;
            phase_reg     <= fpqr_pkg::PH_F1;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg     <= stat_next;
        x1_reg       <= x1_next;
        x2_reg       <= x2_next;
        x0_reg       <= x0_next;
        ex_reg       <= ex_next;
        root_reg     <= root_next;
        f1_reg       <= f1_next;
        f2_reg       <= f2_next;
        f0_reg       <= f0_next;
        sqp_reg      <= sqp_next;
        sq_reg       <= sq_next;
        qup_reg      <= qup_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        out_root_reg <= out_root_next;
        out_stat_reg <= out_stat_next;
        out_cnt_reg  <= out_cnt_next;
    end

endmodule

[hdl/false_position_quartic_root.sv]
// Top level of the false position root finder for x^4 - 5x^2 + 4.
//
// Input stream: each request carries the low end of a bracket (signed Q3.16).
// The high end is low + bracket_width, saturated at the largest Q3.16 value.
// Output stream: one result per request, in order: root estimate, outcome
// code (none, low end, high end, iterated, cap hit) and iteration count.
// Config port: write tolerance (index 0) and bracket_width (index 1) only
// while the block is idle; values take effect on the next request.
//
// Each false position iteration is dominated by the bit-serial divider (one
// quotient bit per cycle over a 53-bit dividend) plus a quartic evaluation
// through the S_SQ, S_QU and S_FV states; the default iteration cap is 64.
// One request is worked on at a time; a two-deep queue in front of the
// sequencer takes new requests while one is in progress.
//
// Reset clears the queue, the sequencer and output valid, and loads
// tolerance 66 and bracket_width 0.5. A stalled output holds its result;
// the sequencer waits to post the next one and the queue fills, then
// s_axis_tready drops.
module false_position_quartic_root #(
    parameter int MAX_ITERATIONS = fpqr_pkg::MAX_ITERATIONS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [23:0]                          s_axis_tdata,  // [19:0] bracket_low
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [19:0] root_value, [26:20] iteration_count
    output logic [31:0]                          m_axis_tdata,
    output logic [fpqr_pkg::STAT_W-1:0]          m_axis_tuser,  // [2:0] status
    input  logic                                 cfg_wr_en,
    input  logic [fpqr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fpqr_pkg::CFG_W-1:0]           cfg_data
);

    logic [fpqr_pkg::TOL_W-1:0] tolerance_reg;
    logic [fpqr_pkg::BW_W-1:0]  bracket_width_reg;

    fpqr_pkg::job_t          front_job, q_job;
    logic                    q_full, q_empty, q_pop;
    fpqr_pkg::fix_t          root_value;
    logic [fpqr_pkg::CNT_OUT_W-1:0] iteration_count;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg     <= fpqr_pkg::TOL_RST;
            bracket_width_reg <= fpqr_pkg::BW_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fpqr_pkg::REG_TOLERANCE:
                    tolerance_reg <= cfg_data[fpqr_pkg::TOL_W-1:0];
                fpqr_pkg::REG_BRACKET_WIDTH:
                    bracket_width_reg <= cfg_data[fpqr_pkg::BW_W-1:0];
                default:
                    tolerance_reg <= tolerance_reg;
            endcase
        end
    end

    fpqr_front u_front (
        .bracket_low   (s_axis_tdata[fpqr_pkg::X_W-1:0]),
        .bracket_width (bracket_width_reg),
        .job           (front_job)
    );

    assign s_axis_tready = !q_full;

    fpqr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s_axis_tvalid),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_job),
        .empty    (q_empty)
    );

    fpqr_back #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (!q_empty),
        .job             (q_job),
        .job_pop         (q_pop),
        .tolerance       (tolerance_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .root_value      (root_value),
        .status          (m_axis_tuser),
        .iteration_count (iteration_count)
    );

    assign m_axis_tdata = {5'b00000, iteration_count, root_value};

    // no sign change reports a zero root
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == fpqr_pkg::ST_NONE |-> m_axis_tdata[19:0] == 20'd0)
        else $error("no-root result with nonzero root value");

    // endpoint hits never iterate
    a_end_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == fpqr_pkg::ST_LOW || m_axis_tuser == fpqr_pkg::ST_HIGH)
        |-> m_axis_tdata[26:20] == 7'd0)
        else $error("endpoint result with nonzero iteration count");

    // cap flag only with a full iteration count
    a_cap_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == fpqr_pkg::ST_CAP
        |-> 32'(m_axis_tdata[26:20]) == ((MAX_ITERATIONS > 127) ? 127 : MAX_ITERATIONS))
        else $error("cap result with wrong iteration count");

    // sequencer only pulls from a non-empty queue
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

endmodule

[tb/sv/false_position_quartic_root_tb.sv]
// Self-checking testbench for the false position quartic root finder.
module false_position_quartic_root_tb;

    localparam int  MAX_ITER    = fpqr_pkg::MAX_ITERATIONS_DEF;
    // slowest item runs to the iteration cap, plus stalls and gaps; 1000+ items
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef struct {
        fpqr_pkg::fix_t    root;
        fpqr_pkg::status_t status;
        logic [fpqr_pkg::CNT_OUT_W-1:0] count;
    } root_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata = '0;      // [19:0] bracket_low
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [19:0] root_value, [26:20] iteration_count
    logic [fpqr_pkg::STAT_W-1:0] m_axis_tuser;     // [2:0] status
    logic cfg_wr_en = 1'b0;
    logic [fpqr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fpqr_pkg::CFG_W-1:0] cfg_data = '0;

    // local copy of the configuration registers
    longint tol_reg = fpqr_pkg::TOL_RST;
    longint width_reg = fpqr_pkg::BW_RST;

    root_result_t pending_roots[$];
    int     mismatches = 0;
    longint cycles = 0;
    int     burst_left = 0;
    int     ready_mode = 0;

    false_position_quartic_root dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // f(x) = x^4 - 5x^2 + 4 in Q16, floor on both squarings
    function automatic longint quartic_q16(longint x);
        longint sq;
        longint qu;
        sq = (x * x) >>> fpqr_pkg::FRAC_BITS;
        qu = (sq * sq) >>> fpqr_pkg::FRAC_BITS;
        return qu - 5 * sq + (longint'(4) << fpqr_pkg::FRAC_BITS);
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit opposite(longint a, longint b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    function automatic root_result_t find_root(fpqr_pkg::fix_t lo_in);
        root_result_t r;
        longint x1, x2, x0, f1, f2, f0, den, cnt;
        x1 = lo_in;
        x2 = x1 + width_reg;
        if (x2 > longint'(fpqr_pkg::X_MAX_V)) x2 = fpqr_pkg::X_MAX_V;
        f1 = quartic_q16(x1);
        f2 = quartic_q16(x2);
        cnt = 0;
        r.root = '0;
        r.status = fpqr_pkg::ST_NONE;
        if (magnitude(f1) < tol_reg)
        begin
            r.root = fpqr_pkg::fix_t'(x1);
            r.status = fpqr_pkg::ST_LOW;
        end
        else if (magnitude(f2) < tol_reg)
        begin
            r.root = fpqr_pkg::fix_t'(x2);
            r.status = fpqr_pkg::ST_HIGH;
        end
        else if (opposite(f1, f2))
        begin
            x0 = x1;
            r.status = fpqr_pkg::ST_ITER;
            while (magnitude(x2 - x1) > tol_reg)
            begin
                if (cnt >= MAX_ITER)
                begin
                    r.status = fpqr_pkg::ST_CAP;
                    break;
                end
                den = f2 - f1;
                if (den == 0) break;
                cnt++;
                x0 = (x1 * f2 - x2 * f1) / den;   // truncates toward zero
                f0 = quartic_q16(x0);
                if (magnitude(f0) < tol_reg) break;
                if (opposite(f0, f1))
                begin
                    x2 = x0;
                    f2 = f0;
                end
                else
                begin
                    x1 = x0;
                    f1 = f0;
                end
            end
            if (x0 < longint'(fpqr_pkg::X_MIN_V)) x0 = fpqr_pkg::X_MIN_V;
            if (x0 > longint'(fpqr_pkg::X_MAX_V)) x0 = fpqr_pkg::X_MAX_V;
            r.root = fpqr_pkg::fix_t'(x0);
        end
        r.count = cnt > 127 ? 7'd127 : cnt[fpqr_pkg::CNT_OUT_W-1:0];
        return r;
    endfunction

    // sender: bursts of random length with random idle gaps in between
    task automatic send_bracket(fpqr_pkg::fix_t lo);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, lo};
        do @(posedge clk); while (!s_axis_tready);
        pending_roots.insert(pending_roots.size(), find_root(lo));
        burst_left--;
    endtask

    // wait until every expected result has come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_roots.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_reg(logic [fpqr_pkg::CFG_IDX_W-1:0] idx, longint value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= fpqr_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == fpqr_pkg::REG_TOLERANCE) tol_reg = value & 16'hFFFF;
        else width_reg = value & 19'h7FFFF;
        @(posedge clk);
    endtask

    // mostly brackets placed near one of the roots +-1, +-2; rest anywhere
    function automatic fpqr_pkg::fix_t random_bracket();
        longint root_pos;
        longint lo;
        if ($urandom_range(0, 9) < 3) return fpqr_pkg::fix_t'($urandom);
        case ($urandom_range(0, 3))
            0: root_pos = -2;
            1: root_pos = -1;
            2: root_pos = 1;
            default: root_pos = 2;
        endcase
        lo = (root_pos <<< fpqr_pkg::FRAC_BITS)
             - longint'($urandom_range(0, width_reg + 64)) + 32;
        return fpqr_pkg::fix_t'(lo);
    endfunction

    task automatic test_directed;
        fpqr_pkg::fix_t list[$];
        list = '{fpqr_pkg::X_MIN_V, fpqr_pkg::X_MAX_V, 20'sd0, 20'sd65536, 20'sd98304,
                 20'sd49152, 20'sd114688, -20'sd81920, -20'sd147456,
                 -20'sd65536, -20'sd131072, 20'sd131072, 20'sd491520,
                 -20'sd1, 20'sd1, 20'sd300000};
        foreach (list[i]) send_bracket(list[i]);
        drain();
    endtask

    // bracket no wider than the tolerance across a root: no iteration
    task automatic test_narrow_bracket;
        write_reg(fpqr_pkg::REG_BRACKET_WIDTH, 50);
        send_bracket(20'sd65516);
        send_bracket(-20'sd65536 - 20'sd30);
        send_bracket(20'sd131050);
        drain();
        write_reg(fpqr_pkg::REG_BRACKET_WIDTH, 1);
        send_bracket(20'sd65535);
        send_bracket(fpqr_pkg::X_MAX_V);
        drain();
    endtask

    // tolerance 1 and the widest bracket: long runs and the iteration cap
    task automatic test_tight_tolerance;
        write_reg(fpqr_pkg::REG_TOLERANCE, 1);
        write_reg(fpqr_pkg::REG_BRACKET_WIDTH, 262144);
        send_bracket(20'sd0);
        send_bracket(-20'sd196608);
        send_bracket(20'sd32768);
        send_bracket(20'sd300000);
        send_bracket(-20'sd100000);
        drain();
    endtask

    task automatic test_loose_tolerance;
        write_reg(fpqr_pkg::REG_TOLERANCE, 65535);
        write_reg(fpqr_pkg::REG_BRACKET_WIDTH, 32768);
        send_bracket(20'sd49152);
        send_bracket(20'sd0);
        send_bracket(-20'sd150000);
        drain();
    endtask

    task automatic test_random;
        longint tol_set[5] = '{66, 1, 65535, 500, 8};
        longint width_set[5] = '{32768, 262144, 1, 100000, 4000};
        int n;
        for (int p = 0; p < 5; p++)
        begin
            write_reg(fpqr_pkg::REG_TOLERANCE, tol_set[p]);
            write_reg(fpqr_pkg::REG_BRACKET_WIDTH, width_set[p]);
            n = (tol_set[p] == 1) ? 100 : 225;
            for (int i = 0; i < n; i++)
            begin
                send_bracket(random_bracket());
                // pause once with nothing in flight
                if (p == 0 && i == 100) drain();
            end
            drain();
        end
    endtask

    // receiver: randomly chosen stall pattern, switching mode periodically
    always @(posedge clk)
    begin
        root_result_t exp_r;
        cycles <= cycles + 1;
        if (cycles % 300 == 0) ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (cycles % 7) < 4;
        endcase
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                exp_r = pending_roots.pop_front();
                if (m_axis_tdata[19:0] !== exp_r.root ||
                    m_axis_tuser !== exp_r.status ||
                    m_axis_tdata[26:20] !== exp_r.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp root %0d st %0d cnt %0d, got %0d %0d %0d",
                                 exp_r.root, exp_r.status, exp_r.count,
                                 $signed(m_axis_tdata[19:0]), m_axis_tuser,
                                 m_axis_tdata[26:20]);
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_narrow_bracket();
        test_tight_tolerance();
        test_loose_tolerance();
        test_random();
        if (mismatches == 0 && pending_roots.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
